@@ src/dqd_pkg.sv @@
// ----------------------------------------------------------------------------
// Deque package
// Shared constants, operation codes and interface types of the deque block.
// ----------------------------------------------------------------------------
package dqd_pkg;

    localparam int DEPTH   = 32;
    localparam int SLOT_W  = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int VALUE_W = 32;

    localparam logic [1:0] MODE_PUSH_HEAD = 2'd0;
    localparam logic [1:0] MODE_PUSH_TAIL = 2'd1;
    localparam logic [1:0] MODE_POP_HEAD  = 2'd2;
    localparam logic [1:0] MODE_POP_TAIL  = 2'd3;

    typedef struct packed {
        logic [1:0]                mode;
        logic signed [VALUE_W-1:0] push_value;
    } request_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] item_value;
        logic                      last;
        logic                      dropped;
    } result_t;

    typedef struct packed {
        logic load;
        logic update;
        logic read;
    } dqd_cmd_t;

    typedef struct packed {
        logic empty_next;
        logic at_last;
    } dqd_status_t;

endpackage

@@ src/dqd_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dqd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/dqd_dpath.sv @@
// ----------------------------------------------------------------------------
// Deque datapath
// Holds the request, the head slot, the entry count, the ring store and the
// dump index, and carries out the commands of the controller.
// ----------------------------------------------------------------------------
module dqd_dpath
    import dqd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  request_t                  request,
    input  dqd_cmd_t                  cmd,
    output dqd_status_t               status,
    output logic signed [VALUE_W-1:0] rd_value,
    output logic                      dropped
);

    localparam logic [COUNT_W-1:0] DEPTH_C    = COUNT_W'(DEPTH);
    localparam logic [COUNT_W:0]   DEPTH_WIDE = (COUNT_W + 1)'(DEPTH);
    localparam logic [SLOT_W-1:0]  LAST_SLOT  = SLOT_W'(DEPTH - 1);

    request_t             req_reg;
    logic [SLOT_W-1:0]    head_reg,    head_next;
    logic [COUNT_W-1:0]   count_reg,   count_next;
    logic [SLOT_W-1:0]    index_reg,   index_next;
    logic                 dropped_reg, dropped_next;

    logic                 full;
    logic                 empty;
    logic [SLOT_W-1:0]    head_dec;
    logic [SLOT_W-1:0]    head_inc;
    logic [COUNT_W:0]     tail_sum;
    logic [SLOT_W-1:0]    tail_slot;
    logic [COUNT_W:0]     read_sum;
    logic [SLOT_W-1:0]    read_slot;
    logic                 we;
    logic [SLOT_W-1:0]    waddr;
    logic [VALUE_W-1:0]   rdata;

    assign full     = (count_reg == DEPTH_C);
    assign empty    = (count_reg == '0);
    assign head_dec = (head_reg == '0) ? LAST_SLOT : head_reg - 1'b1;
    assign head_inc = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;

    assign tail_sum  = (COUNT_W + 1)'(head_reg) + (COUNT_W + 1)'(count_reg);
    assign tail_slot = (tail_sum >= DEPTH_WIDE) ? SLOT_W'(tail_sum - DEPTH_WIDE)
                                                : SLOT_W'(tail_sum);
    assign read_sum  = (COUNT_W + 1)'(head_reg) + (COUNT_W + 1)'(index_reg);
    assign read_slot = (read_sum >= DEPTH_WIDE) ? SLOT_W'(read_sum - DEPTH_WIDE)
                                                : SLOT_W'(read_sum);

    always_comb
    begin
        head_next    = head_reg;
        count_next   = count_reg;
        index_next   = index_reg;
        dropped_next = dropped_reg;
        we           = 1'b0;
        waddr        = tail_slot;
        if (cmd.update)
        begin
            index_next   = '0;
            dropped_next = 1'b0;
            unique case (req_reg.mode)
                MODE_PUSH_HEAD:
                begin
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        head_next  = head_dec;
                        count_next = count_reg + 1'b1;
                        we         = 1'b1;
                        waddr      = head_dec;
                    end
                end
                MODE_PUSH_TAIL:
                begin
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                        we         = 1'b1;
                    end
                end
                MODE_POP_HEAD:
                begin
                    if (!empty)
                    begin
                        head_next  = head_inc;
                        count_next = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    if (!empty)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
            endcase
        end
        else if (cmd.read)
        begin
            index_next = index_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            count_reg   <= '0;
            index_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            count_reg   <= count_next;
            index_reg   <= index_next;
            dropped_reg <= dropped_next;
        end
    end

    dqd_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (req_reg.push_value),
        .re    (cmd.read),
        .raddr (read_slot),
        .rdata (rdata)
    );

    assign status.empty_next = (req_reg.mode == MODE_POP_HEAD ||
                                req_reg.mode == MODE_POP_TAIL) &&
                               (count_reg <= COUNT_W'(1));
    assign status.at_last    = ((COUNT_W)'(index_reg) + 1'b1 == count_reg);
    assign rd_value          = rdata;
    assign dropped           = dropped_reg;

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= DEPTH_C)
        else $error("Entry count exceeds the ring depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && count_reg == DEPTH_C &&
         (req_reg.mode == MODE_PUSH_HEAD || req_reg.mode == MODE_PUSH_TAIL))
        |=> (dropped_reg && $stable(count_reg) && $stable(head_reg)))
        else $error("A push into a full queue changed the queue.");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read |-> ((COUNT_W)'(index_reg) < count_reg))
        else $error("Dump read beyond the entries held.");

endmodule

@@ src/dqd_ctrl.sv @@
// ----------------------------------------------------------------------------
// Deque controller
// Sequences the accept, update and dump phases of each request.
// ----------------------------------------------------------------------------
module dqd_ctrl
    import dqd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  dqd_status_t status,
    output dqd_cmd_t    cmd,
    output logic        strobe,
    output logic        last
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_UPDATE = 2'd1;
    localparam logic [1:0] ST_READ   = 2'd2;

    logic [1:0] state_reg,  state_next;
    logic       strobe_reg, strobe_next;
    logic       last_reg,   last_next;

    always_comb
    begin
        state_next  = state_reg;
        strobe_next = 1'b0;
        last_next   = 1'b0;
        cmd.load    = 1'b0;
        cmd.update  = 1'b0;
        cmd.read    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = status.empty_next ? ST_IDLE : ST_READ;
            end
            ST_READ:
            begin
                cmd.read    = 1'b1;
                strobe_next = 1'b1;
                last_next   = status.at_last;
                if (status.at_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign last   = last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == ST_UPDATE))
        else $error("An accepted request did not enter the update phase.");

    assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> $past(state_reg == ST_READ))
        else $error("A result appeared without a preceding dump read.");

    assert property (@(posedge clk) disable iff (!rst_n)
        last_reg |=> (state_reg == ST_IDLE && !strobe_reg) || (state_reg == ST_UPDATE))
        else $error("The dump went on after its last entry.");

endmodule

@@ src/deque_with_content_dump.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue with content dump
// A bounded deque of signed 32-bit values in a ring store; after each
// request the whole contents are listed from head to tail.
// ----------------------------------------------------------------------------
//  Channel   Signals                      Handshake
//  request   request (mode, push_value)   taken when start is high, busy low
//  result    result (item_value, last,    one entry per cycle, marked by
//            dropped)                     strobe, cannot be held off
//
//  A request steps through an accept, an update of the ring, and then one
//  read of the ring RAM per entry left after the operation.
//  The single read port of the ring RAM sets the dump to one entry a cycle.
//  Results come in the cycle after their reads; the last appears as busy falls.
//  Reset clears the head slot and the entry count; the ring needs no clearing.
//  The receiver cannot stall the dump.
// ----------------------------------------------------------------------------
module deque_with_content_dump
    import dqd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  request_t request,
    output logic     strobe,
    output result_t  result
);

    dqd_cmd_t                  cmd;
    dqd_status_t               status;
    logic signed [VALUE_W-1:0] rd_value;
    logic                      dropped;
    logic                      last;

    dqd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd),
        .strobe (strobe),
        .last   (last)
    );

    dqd_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .cmd      (cmd),
        .status   (status),
        .rd_value (rd_value),
        .dropped  (dropped)
    );

    assign result.item_value = rd_value;
    assign result.last       = last;
    assign result.dropped    = dropped;

endmodule

@@ tb/tb_deque_with_content_dump.sv @@
// ----------------------------------------------------------------------------
// Deque with content dump testbench
// Sends push and pop requests in random bursts and predicts the contents
// listed after each request. Every listed entry is checked against the
// prediction, field by field.
// ----------------------------------------------------------------------------
module tb_deque_with_content_dump;
    timeunit 1ns;
    timeprecision 1ps;

    import dqd_pkg::*;

    typedef struct {
        request_t req;
        bit       drain;
    } pending_t;

    logic     clk     = 1'b0;
    logic     rst_n   = 1'b0;
    logic     start   = 1'b0;
    request_t request = '0;
    logic     busy;
    logic     strobe;
    result_t  result;

    logic signed [VALUE_W-1:0] ring_copy [DEPTH];
    int       head_copy   = 0;
    int       count_copy  = 0;
    result_t  dump_expected [$];
    pending_t pending_q [$];

    int       errors      = 0;
    int       taken_count = 0;
    int       seen_count  = 0;
    int       burst_left  = 1;
    int       gap_left    = 0;
    bit       item_live   = 1'b0;
    request_t item_cur    = '0;

    always #1 clk = ~clk;

    deque_with_content_dump dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .strobe  (strobe),
        .result  (result)
    );

    function automatic void predict_dump(request_t rq);
        bit      refused;
        result_t r;
        refused = 1'b0;
        case (rq.mode)
            MODE_PUSH_HEAD:
            begin
                if (count_copy >= DEPTH)
                begin
                    refused = 1'b1;
                end
                else
                begin
                    head_copy = (head_copy + DEPTH - 1) % DEPTH;
                    ring_copy[head_copy] = rq.push_value;
                    count_copy++;
                end
            end
            MODE_PUSH_TAIL:
            begin
                if (count_copy >= DEPTH)
                begin
                    refused = 1'b1;
                end
                else
                begin
                    ring_copy[(head_copy + count_copy) % DEPTH] = rq.push_value;
                    count_copy++;
                end
            end
            MODE_POP_HEAD:
            begin
                if (count_copy > 0)
                begin
                    head_copy = (head_copy + 1) % DEPTH;
                    count_copy--;
                end
            end
            default:
            begin
                if (count_copy > 0)
                begin
                    count_copy--;
                end
            end
        endcase
        for (int k = 0; k < count_copy; k++)
        begin
            r.item_value = ring_copy[(head_copy + k) % DEPTH];
            r.last       = (k == count_copy - 1);
            r.dropped    = refused;
            dump_expected.push_back(r);
        end
    endfunction

    function automatic void check_entry(result_t got);
        result_t want;
        if (dump_expected.size() == 0)
        begin
            $error("unexpected entry: item_value %0d last %0b dropped %0b",
                   got.item_value, got.last, got.dropped);
            errors++;
            return;
        end
        want = dump_expected.pop_front();
        if (got.item_value !== want.item_value)
        begin
            $error("item_value: expected %0d, actual %0d", want.item_value, got.item_value);
            errors++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %0b, actual %0b", want.last, got.last);
            errors++;
        end
        if (got.dropped !== want.dropped)
        begin
            $error("dropped: expected %0b, actual %0b", want.dropped, got.dropped);
            errors++;
        end
    endfunction

    function automatic void queue_request(logic [1:0] op, logic signed [VALUE_W-1:0] value,
                                          bit drain);
        pending_t p;
        p.req.mode       = op;
        p.req.push_value = value;
        p.drain          = drain;
        pending_q.push_back(p);
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return $signed($urandom_range(0, 15)) - 8;
            default: return $urandom;
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (strobe === 1'b1)
            begin
                check_entry(result);
            end
            if (start && busy === 1'b0)
            begin
                predict_dump(request);
                taken_count++;
            end
        end
    end

    always @(negedge clk)
    begin
        pending_t p;
        if (rst_n)
        begin
            if (item_live && taken_count != seen_count)
            begin
                item_live  = 1'b0;
                seen_count = taken_count;
            end
            if (!item_live)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_q.size() > 0 &&
                         !(pending_q[0].drain && dump_expected.size() != 0))
                begin
                    p         = pending_q.pop_front();
                    item_cur  = p.req;
                    item_live = 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                                 : $urandom_range(1, 8);
                        gap_left   = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
                                                                 : $urandom_range(0, 5);
                    end
                end
            end
            start <= item_live;
            if (item_live)
            begin
                request <= item_cur;
            end
            else
            begin
                request <= {2'($urandom), 32'($urandom)};
            end
        end
    end

    initial
    begin
        int         push_pct [8];
        logic [1:0] op;
        push_pct = '{100, 0, 85, 20, 50, 90, 20, 50};

        // Empty pops, both ring wraps, extreme values and a full drain.
        queue_request(MODE_POP_HEAD, 32'sh0000_1234, 1'b0);
        queue_request(MODE_POP_TAIL, -32'sd1, 1'b0);
        queue_request(MODE_PUSH_HEAD, 32'sh7FFF_FFFF, 1'b0);
        queue_request(MODE_POP_HEAD, 32'sd0, 1'b0);
        queue_request(MODE_PUSH_TAIL, 32'sh8000_0000, 1'b0);
        queue_request(MODE_PUSH_HEAD, 32'sd0, 1'b0);
        queue_request(MODE_PUSH_TAIL, -32'sd1, 1'b0);
        queue_request(MODE_PUSH_HEAD, 32'sd1, 1'b0);
        queue_request(MODE_PUSH_TAIL, 32'sh5555_5555, 1'b0);
        queue_request(MODE_PUSH_HEAD, 32'shAAAA_AAAA, 1'b0);
        queue_request(MODE_POP_TAIL, 32'sd0, 1'b0);
        queue_request(MODE_POP_HEAD, 32'sd0, 1'b0);
        queue_request(MODE_POP_TAIL, 32'sd0, 1'b0);
        queue_request(MODE_POP_HEAD, 32'sd0, 1'b0);
        queue_request(MODE_POP_HEAD, 32'sd0, 1'b0);
        queue_request(MODE_POP_HEAD, 32'sd0, 1'b0);
        queue_request(MODE_POP_TAIL, 32'sd7, 1'b1);

        // Phases lean towards pushes or pops so that the queue fills and empties.
        foreach (push_pct[ph])
        begin
            for (int i = 0; i < 38; i++)
            begin
                if ($urandom_range(1, 100) <= push_pct[ph])
                begin
                    op = $urandom_range(0, 1) ? MODE_PUSH_TAIL : MODE_PUSH_HEAD;
                end
                else
                begin
                    op = $urandom_range(0, 1) ? MODE_POP_TAIL : MODE_POP_HEAD;
                end
                queue_request(op, pick_value(), (ph == 4 && i == 0));
            end
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (pending_q.size() != 0 || item_live || dump_expected.size() != 0);
        repeat (DEPTH + 4) @(posedge clk);

        if (errors == 0 && dump_expected.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    initial
    begin
        #400us;
        $display("FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
src/dqd_pkg.sv
src/dqd_ram.sv
src/dqd_dpath.sv
src/dqd_ctrl.sv
src/deque_with_content_dump.sv
tb/tb_deque_with_content_dump.sv
